/* rtl/flmpnl_pkg.sv */
// Shared types, sizes and helpers for the lot-matching PnL block.
package flmpnl_pkg;

  // Store and field sizes
  localparam int MAX_LOTS   = 64;
  localparam int IDX_BITS   = $clog2(MAX_LOTS);
  localparam int CNT_BITS   = $clog2(MAX_LOTS + 1);
  localparam int PRICE_BITS = 32;
  localparam int QTY_BITS   = 24;
  localparam int PNL_BITS   = 58;
  localparam int STAMP_BITS = 32;
  localparam int SYM_BITS   = 16;
  localparam int DIFF_BITS  = PRICE_BITS + 1;
  localparam int PROD_BITS  = QTY_BITS + 1 + DIFF_BITS;

  // Trade sides
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // Match order codes
  localparam logic ORDER_FIFO = 1'b0;
  localparam logic ORDER_LIFO = 1'b1;

  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [PRICE_BITS-1:0] price_t;
  typedef logic [QTY_BITS-1:0]   qty_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_MUL,
    ST_ACC,
    ST_APPEND,
    ST_DONE
  } state_t;

  // Circular slot: base plus offset, wrapped once; correct while the sum stays below twice the depth
  function automatic idx_t slot_wrap(input idx_t base, input cnt_t offs);
    logic [CNT_BITS:0] sum;
    sum = {{(CNT_BITS + 1 - IDX_BITS){1'b0}}, base} + {1'b0, offs};
    if (sum >= (CNT_BITS + 1)'(MAX_LOTS)) begin
      sum = sum - (CNT_BITS + 1)'(MAX_LOTS);
    end
    return sum[IDX_BITS-1:0];
  endfunction

endpackage

/* rtl/fifo_lifo_lot_matcher_pnl_unit.sv */
// Lot-matching realized-PnL unit: trade sequencer, lot store and shared multiply-accumulate.
//
// Each trade request is matched against the open lots of the opposite side, oldest lot first
// (match order 0) or newest first (match order 1), and gives one result with the realized PnL,
// the pass-through tags and a flag for a remainder that found the store full. A small sequencer
// drives one lot-store read port and one shared multiplier: each lot that a trade touches passes
// through the states READ, CALC, MUL and ACC (store read, match and write-back, multiply,
// accumulate), and the next trade is accepted only once the result has gone into the output
// register; a stalled result holds the sequencer before it loads the output register. The lot
// store holds 64 lots and needs no clearing after reset. in_ready is high only when no trade is
// in progress. The match order register may be written whenever no trade is in progress.
module fifo_lifo_lot_matcher_pnl_unit
  import flmpnl_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  // trade requests
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_side,
  input  logic [PRICE_BITS-1:0]      in_price,
  input  logic [QTY_BITS-1:0]        in_quantity,
  input  logic [STAMP_BITS-1:0]      in_timestamp,
  input  logic [SYM_BITS-1:0]        in_symbol_id,
  // results
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_traded,
  output logic signed [PNL_BITS-1:0] out_pnl,
  output logic [STAMP_BITS-1:0]      out_timestamp,
  output logic [SYM_BITS-1:0]        out_symbol_id,
  output logic                       out_remainder_dropped
);

  // Control state
  state_t state_r, state_nxt;
  logic   match_order_r;
  idx_t   oldest_r;
  cnt_t   count_r;
  logic   book_side_r;
  logic   out_valid_r;

  // Trade in progress
  logic                       side_r;
  price_t                     price_r;
  qty_t                       rem_r;
  logic [STAMP_BITS-1:0]      stamp_r;
  logic [SYM_BITS-1:0]        sym_r;
  logic                       traded_r;
  logic                       dropped_r;
  idx_t                       slot_r;
  qty_t                       match_r;
  logic signed [DIFF_BITS-1:0] diff_r;
  logic signed [PROD_BITS-1:0] prod_r;
  logic signed [PNL_BITS-1:0] acc_r;

  // Output register payload
  logic                       out_traded_r;
  logic signed [PNL_BITS-1:0] out_pnl_r;
  logic [STAMP_BITS-1:0]      out_stamp_r;
  logic [SYM_BITS-1:0]        out_sym_r;
  logic                       out_dropped_r;

  // Lot store
  price_t lot_price_mem [MAX_LOTS];
  qty_t   lot_qty_mem   [MAX_LOTS];
  price_t rd_price_r;
  qty_t   rd_qty_r;

  // Combinational helpers
  logic   accept;
  logic   load_out;
  logic   store_full;
  logic   can_rest;
  idx_t   rd_slot;
  idx_t   tail_slot;
  qty_t   cur_match;
  logic   lot_used_up;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state_r == ST_IDLE);
  assign load_out   = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign store_full = (count_r == CNT_BITS'(MAX_LOTS));
  assign can_rest   = (rem_r != '0) && !store_full;

  // Slot to match next and slot for a new lot
  assign rd_slot   = (match_order_r == ORDER_LIFO) ? slot_wrap(oldest_r, count_r - cnt_t'(1))
                                                   : oldest_r;
  assign tail_slot = slot_wrap(oldest_r, count_r);

  // Matched quantity of the lot just read
  assign lot_used_up = (rd_qty_r <= rem_r);
  assign cur_match   = lot_used_up ? rd_qty_r : rem_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if ((count_r != '0) && (in_side != book_side_r) && (in_quantity != '0)) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_APPEND;
          end
        end
      end
      ST_READ:   state_nxt = ST_CALC;
      ST_CALC:   state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_ACC;
      ST_ACC: begin
        if ((rem_r != '0) && (count_r != '0)) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_APPEND;
        end
      end
      ST_APPEND: state_nxt = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_order_r <= ORDER_FIFO;
    end else if (cfg_we) begin
      match_order_r <= cfg_wdata;
    end
  end

  // Book control: head, count and side
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r    <= '0;
      count_r     <= '0;
      book_side_r <= SIDE_BUY;
    end else begin
      if ((state_r == ST_CALC) && lot_used_up) begin
        count_r <= count_r - cnt_t'(1);
        if (match_order_r == ORDER_FIFO) begin
          oldest_r <= slot_wrap(oldest_r, cnt_t'(1));
        end
      end
      if ((state_r == ST_APPEND) && (rem_r != '0)) begin
        if (count_r == '0) begin
          book_side_r <= side_r;
        end
        if (!store_full) begin
          count_r <= count_r + cnt_t'(1);
        end
      end
    end
  end

  // Trade datapath and shared multiply-accumulate
  always_ff @(posedge clk) begin
    if (accept) begin
      side_r    <= in_side;
      price_r   <= in_price;
      rem_r     <= in_quantity;
      stamp_r   <= in_timestamp;
      sym_r     <= in_symbol_id;
      traded_r  <= 1'b0;
      dropped_r <= 1'b0;
      acc_r     <= '0;
    end
    if (state_r == ST_READ) begin
      slot_r <= rd_slot;
    end
    if (state_r == ST_CALC) begin
      match_r  <= cur_match;
      rem_r    <= rem_r - cur_match;
      traded_r <= 1'b1;
      // sell gains trade minus lot price, buy gains lot minus trade price
      if (side_r == SIDE_SELL) begin
        diff_r <= $signed({1'b0, price_r}) - $signed({1'b0, rd_price_r});
      end else begin
        diff_r <= $signed({1'b0, rd_price_r}) - $signed({1'b0, price_r});
      end
    end
    if (state_r == ST_MUL) begin
      prod_r <= $signed({1'b0, match_r}) * diff_r;
    end
    if (state_r == ST_ACC) begin
      acc_r <= acc_r + PNL_BITS'(prod_r);
    end
    if ((state_r == ST_APPEND) && (rem_r != '0) && store_full) begin
      dropped_r <= 1'b1;
    end
  end

  // Lot store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      lot_qty_mem[slot_r] <= rd_qty_r - cur_match;
    end else if ((state_r == ST_APPEND) && can_rest) begin
      lot_qty_mem[tail_slot]   <= rem_r;
      lot_price_mem[tail_slot] <= price_r;
    end
    if (state_r == ST_READ) begin
      rd_qty_r   <= lot_qty_mem[rd_slot];
      rd_price_r <= lot_price_mem[rd_slot];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_traded_r  <= traded_r;
      out_pnl_r     <= traded_r ? acc_r : '0;
      out_stamp_r   <= stamp_r;
      out_sym_r     <= sym_r;
      out_dropped_r <= dropped_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_traded            = out_traded_r;
  assign out_pnl               = out_pnl_r;
  assign out_timestamp         = out_stamp_r;
  assign out_symbol_id         = out_sym_r;
  assign out_remainder_dropped = out_dropped_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_BITS'(MAX_LOTS))
    else $error("lot count beyond store depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("request accepted while a trade is in progress");

  a_pnl_zero_untraded: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_traded) |-> (out_pnl == '0))
    else $error("nonzero pnl on a result without a match");

  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_APPEND && rem_r != '0 && !store_full) |=> !dropped_r)
    else $error("remainder dropped with room in the store");

endmodule

/* verif/fifo_lifo_lot_matcher_pnl_unit_test.sv */
// Self-checking testbench for the FIFO/LIFO lot-matching realized-PnL unit.
module fifo_lifo_lot_matcher_pnl_unit_test
  import flmpnl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 10;
  localparam int SETTLE_CYC   = 8;
  localparam int LONG_STALL   = 300;
  localparam int PRICE_CENTER = 1000000;

  typedef struct packed {
    logic                  side;
    price_t                price;
    qty_t                  qty;
    logic [STAMP_BITS-1:0] stamp;
    logic [SYM_BITS-1:0]   sym;
  } trade_t;

  typedef struct packed {
    logic                  traded;
    logic [PNL_BITS-1:0]   pnl;
    logic [STAMP_BITS-1:0] stamp;
    logic [SYM_BITS-1:0]   sym;
    logic                  dropped;
  } fill_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  trade_t offer = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_traded;
  logic signed [PNL_BITS-1:0] out_pnl;
  logic [STAMP_BITS-1:0] out_timestamp;
  logic [SYM_BITS-1:0] out_symbol_id;
  logic out_remainder_dropped;
  logic in_taken = 1'b0;

  // Predicted book: circular lot store, head slot, lot count, book side, match order
  price_t book_px [MAX_LOTS];
  qty_t   book_qty [MAX_LOTS];
  int     head_slot = 0;
  int     open_lots = 0;
  logic   held_side = SIDE_BUY;
  logic   pick_order = ORDER_FIFO;

  trade_t       trades_to_send [$];
  fill_report_t pnl_reports_due [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_reqs = 0;
  int stall_served = 0;
  int stall_left = 0;

  int mismatches = 0;
  int trades_taken = 0;
  int reports_checked = 0;
  int matched_seen = 0;
  int drops_seen = 0;
  int deepest_book = 0;

  fifo_lifo_lot_matcher_pnl_unit i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_side               (offer.side),
    .in_price              (offer.price),
    .in_quantity           (offer.qty),
    .in_timestamp          (offer.stamp),
    .in_symbol_id          (offer.sym),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_traded            (out_traded),
    .out_pnl               (out_pnl),
    .out_timestamp         (out_timestamp),
    .out_symbol_id         (out_symbol_id),
    .out_remainder_dropped (out_remainder_dropped)
  );

  always #(CLK_HALF) clk = ~clk;

  // Match one trade against the predicted book and return its expected report
  function automatic fill_report_t match_trade(input trade_t t);
    fill_report_t r;
    qty_t         rem;
    qty_t         take;
    int           slot;
    logic [63:0]  acc;
    logic [63:0]  gap;
    r = '0;
    rem = t.qty;
    acc = '0;
    if (open_lots > 0 && t.side != held_side) begin
      while (rem != 0 && open_lots > 0) begin
        slot = (pick_order == ORDER_LIFO) ? (head_slot + open_lots - 1) % MAX_LOTS : head_slot;
        take = (book_qty[slot] < rem) ? book_qty[slot] : rem;
        // price difference wraps mod 2^64; only the low PNL_BITS survive
        if (t.side == SIDE_SELL) begin
          gap = {32'b0, t.price} - {32'b0, book_px[slot]};
        end else begin
          gap = {32'b0, book_px[slot]} - {32'b0, t.price};
        end
        acc = acc + {40'b0, take} * gap;
        r.traded = 1'b1;
        rem = rem - take;
        book_qty[slot] = book_qty[slot] - take;
        if (book_qty[slot] == '0) begin
          if (pick_order == ORDER_FIFO) begin
            head_slot = (head_slot + 1) % MAX_LOTS;
          end
          open_lots--;
        end
      end
    end
    // leftover rests as newest lot unless the store is full
    if (rem != 0) begin
      if (open_lots == 0) begin
        held_side = t.side;
      end
      if (open_lots >= MAX_LOTS) begin
        r.dropped = 1'b1;
      end else begin
        slot = (head_slot + open_lots) % MAX_LOTS;
        book_px[slot] = t.price;
        book_qty[slot] = rem;
        open_lots++;
        if (open_lots > deepest_book) begin
          deepest_book = open_lots;
        end
      end
    end
    r.pnl = r.traded ? acc[PNL_BITS-1:0] : '0;
    r.stamp = t.stamp;
    r.sym = t.sym;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Request driver: next trade after acceptance, random idle gaps
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (trades_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offer <= trades_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure plus requested long hold-offs
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (stall_served != stall_reqs) begin
      stall_served <= stall_served + 1;
      stall_left <= LONG_STALL;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Scoreboard: check results against oldest expectation, predict accepted requests
  always @(posedge clk) begin : scoreboard
    fill_report_t due;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (pnl_reports_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual ts %0h sym %0h", $time,
                 out_timestamp, out_symbol_id);
        mismatches++;
      end else begin
        due = pnl_reports_due.pop_front();
        check_field("traded", 64'(due.traded), 64'(out_traded));
        check_field("pnl", 64'(due.pnl), 64'($unsigned(out_pnl)));
        check_field("timestamp", 64'(due.stamp), 64'(out_timestamp));
        check_field("symbol_id", 64'(due.sym), 64'(out_symbol_id));
        check_field("remainder_dropped", 64'(due.dropped), 64'(out_remainder_dropped));
        reports_checked++;
        if (out_traded) matched_seen++;
        if (out_remainder_dropped) drops_seen++;
      end
    end
    if (rst_n && in_valid && in_ready) begin
      pnl_reports_due.insert(pnl_reports_due.size(), match_trade(offer));
      trades_taken++;
    end
  end

  task automatic add_trade(input logic s, input price_t p, input qty_t q,
                           input logic [STAMP_BITS-1:0] st, input logic [SYM_BITS-1:0] sy);
    trade_t t;
    t.side = s;
    t.price = p;
    t.qty = q;
    t.stamp = st;
    t.sym = sy;
    trades_to_send.insert(trades_to_send.size(), t);
  endtask

  task automatic add_random_trade(input logic s, input int qty_cap);
    price_t p;
    qty_t   q;
    int     pick;
    p = ($urandom_range(99) < 80) ? price_t'(PRICE_CENTER + $urandom_range(0, 255))
                                  : price_t'($urandom());
    pick = $urandom_range(99);
    if (pick < 1) q = '0;
    else if (pick < 70 || qty_cap > 0) q = qty_t'($urandom_range(1, (qty_cap > 0) ? qty_cap : 16));
    else if (pick < 90) q = qty_t'($urandom_range(1, 4096));
    else q = qty_t'($urandom_range(1, 24'hFFFFFF));
    add_trade(s, p, q, $urandom(), 16'($urandom()));
  endtask

  // Random runs of one side; occasional long runs fill the store
  task automatic queue_random(input int n);
    int   left;
    int   run;
    logic s;
    left = n;
    while (left > 0) begin
      s = 1'($urandom_range(1));
      run = ($urandom_range(99) < 6) ? $urandom_range(55, 75) : $urandom_range(1, 6);
      while (run > 0 && left > 0) begin
        add_random_trade(s, 0);
        run--;
        left--;
      end
    end
  endtask

  // Wait until every request is sent and every result has come back
  task automatic drain();
    while (trades_to_send.size() != 0 || in_valid || pnl_reports_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic set_order(input logic v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    pick_order = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int   total;
    int   k;
    logic fill_side;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, FIFO: extremes, zero quantity, exact empty, side flips
    send_idle_pct = 20;
    recv_idle_pct = 20;
    set_order(ORDER_FIFO);
    add_trade(SIDE_BUY, 100, 24'd10, 32'h0, 16'h0);
    add_trade(SIDE_BUY, 120, 24'd5, 32'h1, 16'h1);
    add_trade(SIDE_SELL, 130, 24'd12, 32'h2, 16'h2);
    add_trade(SIDE_SELL, 32'hFFFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
    add_trade(SIDE_BUY, 32'h0, 24'd1, 32'h4, 16'h4);
    add_trade(SIDE_BUY, 32'hFFFFFFFF, 24'hFFFFFF, 32'h5, 16'h5);
    add_trade(SIDE_SELL, 50, 24'd0, 32'h6, 16'h6);
    add_trade(SIDE_SELL, 32'h0, 24'hFFFFFF, 32'h7, 16'h7);
    add_trade(SIDE_BUY, 5, 24'hFFFFFE, 32'h8, 16'h8);
    add_trade(SIDE_BUY, 7, 24'd0, 32'h9, 16'h9);
    add_trade(SIDE_BUY, 9, 24'd3, 32'hA, 16'hA);
    add_trade(SIDE_BUY, 11, 24'd2, 32'hB, 16'hB);
    add_trade(SIDE_SELL, 20, 24'd4, 32'hC, 16'hC);
    drain();

    // Directed, LIFO: newest lot first, partial and exact sweeps
    set_order(ORDER_LIFO);
    add_trade(SIDE_BUY, 100, 24'd3, 32'hD, 16'hD);
    add_trade(SIDE_BUY, 200, 24'd3, 32'hE, 16'hE);
    add_trade(SIDE_BUY, 300, 24'd3, 32'hF, 16'hF);
    add_trade(SIDE_SELL, 250, 24'd5, 32'h10, 16'h10);
    add_trade(SIDE_SELL, 400, 24'd10, 32'h11, 16'h11);
    add_trade(SIDE_BUY, 1, 24'd2, 32'h12, 16'h12);
    add_trade(SIDE_BUY, 2, 24'd3, 32'h13, 16'h13);
    drain();

    // Long output hold-off while the store fills past capacity
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_side = (open_lots == 0) ? SIDE_SELL : held_side;
    stall_reqs++;
    for (k = 0; k < 70; k++) begin
      add_random_trade(fill_side, 8);
    end
    drain();
    // One opposite trade sweeps the whole full book
    total = 0;
    for (k = 0; k < open_lots; k++) begin
      total += int'(book_qty[(head_slot + k) % MAX_LOTS]);
    end
    add_trade(~fill_side, PRICE_CENTER, qty_t'(total + 3), $urandom(), 16'($urandom()));
    drain();

    // Random phases with different idle mixes and match orders
    send_idle_pct = 34;
    recv_idle_pct = 73;
    set_order(ORDER_FIFO);
    queue_random(350);
    drain();

    send_idle_pct = 73;
    recv_idle_pct = 34;
    set_order(ORDER_LIFO);
    queue_random(350);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_order(ORDER_FIFO);
    queue_random(150);
    drain();
    set_order(ORDER_LIFO);
    queue_random(150);
    drain();

    repeat (20) @(negedge clk);
    $display("Checked %0d results of %0d trades: %0d matched, %0d remainders dropped.",
             reports_checked, trades_taken, matched_seen, drops_seen);
    $display("Book reached %0d lots; FIFO and LIFO, long output stall, full-book sweep.",
             deepest_book);
    if (mismatches == 0) begin
      $display("fifo_lifo_lot_matcher_pnl_unit test passed");
    end else begin
      $display("fifo_lifo_lot_matcher_pnl_unit test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("Timeout with %0d results outstanding", pnl_reports_due.size());
    $display("fifo_lifo_lot_matcher_pnl_unit test failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/flmpnl_pkg.sv
rtl/fifo_lifo_lot_matcher_pnl_unit.sv
verif/fifo_lifo_lot_matcher_pnl_unit_test.sv
